// ----- src/hesf_pkg.sv -----
// shared constants and pipeline record types for the edge spring force block
// no dependencies; used by harmonic_edge_spring_force
package hesf_pkg;

    // stage counts of the iterative sections
    localparam int SQRT_STEPS = 33;
    localparam int CDIV_STEPS = 66;
    localparam int EDIV_STEPS = 40;
    localparam int GDIV_STEPS = 32;

    // register stages from accepted start to the result strobe
    localparam int LATENCY = 4 + SQRT_STEPS + 1 + 3 + 1 + CDIV_STEPS + 2 + 1 + GDIV_STEPS + 1;

    localparam logic [30:0] STIFF_RESET = 31'd65536;
    localparam logic [39:0] ENERGY_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] POS_CAP     = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_CAP     = 32'h8000_0000;

    // record carried through the square root, stretch and divide sections
    typedef struct packed {
        logic [2:0]  neg;     // sign of a-b per axis
        logic [32:0] mag_x;
        logic [32:0] mag_y;
        logic [32:0] mag_z;
        logic [30:0] e0;      // rest length, zero forced to one
        logic [65:0] acc;     // radicand, then coefficient numerator / quotient
        logic [35:0] rem;     // square root or coefficient remainder
        logic [32:0] len;     // root, then edge length
        logic        dneg;    // stretch is negative
        logic [82:0] eacc;    // energy numerator / quotient
        logic [30:0] erem;
        logic        eov;     // energy saturates
    } pipe_t;

    // record carried through the gradient section
    typedef struct packed {
        logic [2:0]       neg;
        logic             dneg;
        logic [32:0]      len;
        logic [39:0]      energy;
        logic [2:0][32:0] rem;
        logic [2:0][31:0] quo;
        logic [2:0]       ov;
    } grad_t;

endpackage

// ----- src/harmonic_edge_spring_force.sv -----
// harmonic edge spring force: length, energy term and endpoint gradients
// of one mesh edge per cycle; depends on hesf_pkg
//
// usage:
//   input transaction: start high with busy low takes a_*, b_* and ref_length
//   on that clock edge. busy stays low, so one edge may enter every cycle.
//   result transaction: done is high for exactly one cycle with the gradients,
//   edge_length, energy_term and degenerate; the receiver cannot hold it off.
//   configuration: cfg_valid with cfg_ready writes cfg_stiffness (K, unsigned Q15.16).
//   cfg_ready is always high; write it only while no edge is in flight.
// one result per accepted edge, in order, throughput one edge per cycle.
// the pipeline is built around the digit-by-digit units: a 33-stage square
//   root, a 66-stage coefficient divider (energy divider runs beside it) and
//   a 32-stage gradient divider, one quotient or root bit per stage.
// reset: clears all stage valid bits (in-flight edges are dropped) and sets
//   stiffness to 1.0. no memories, no clearing pass.
// a zero length edge gives degenerate high and zero gradients.
module harmonic_edge_spring_force (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic        [30:0] ref_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [30:0] cfg_stiffness,
    output logic               done,
    output logic signed [31:0] grad_a_x,
    output logic signed [31:0] grad_a_y,
    output logic signed [31:0] grad_a_z,
    output logic signed [31:0] grad_b_x,
    output logic signed [31:0] grad_b_y,
    output logic signed [31:0] grad_b_z,
    output logic        [33:0] edge_length,
    output logic        [39:0] energy_term,
    output logic               degenerate
);

    // stiffness register
    logic [30:0] stiff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stiff_reg <= hesf_pkg::STIFF_RESET;
        else if (cfg_valid && cfg_ready)
            stiff_reg <= cfg_stiffness;
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // stage 0: differences and magnitudes
    logic [32:0] s0_diff [0:2];
    logic [32:0] s0_mag_next [0:2];
    logic [2:0]  s0_neg_next;
    logic [32:0] s0_mag_reg [0:2];
    logic [2:0]  s0_neg_reg;
    logic [30:0] s0_e0_reg;
    logic        s0_vld_reg;

    always_comb
    begin
        s0_diff[0] = {a_x[31], a_x} - {b_x[31], b_x};
        s0_diff[1] = {a_y[31], a_y} - {b_y[31], b_y};
        s0_diff[2] = {a_z[31], a_z} - {b_z[31], b_z};
        for (int i = 0; i < 3; i++)
        begin
            s0_neg_next[i] = s0_diff[i][32];
            s0_mag_next[i] = s0_diff[i][32] ? 33'd0 - s0_diff[i] : s0_diff[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            s0_mag_reg[i] <= s0_mag_next[i];
        s0_neg_reg <= s0_neg_next;
        s0_e0_reg  <= (ref_length == 31'd0) ? 31'd1 : ref_length;
    end

    // stage 1: partial squares
    logic [33:0] s1_hh_reg [0:2];
    logic [32:0] s1_hl_reg [0:2];
    logic [31:0] s1_ll_reg [0:2];
    logic [32:0] s1_mag_reg [0:2];
    logic [2:0]  s1_neg_reg;
    logic [30:0] s1_e0_reg;
    logic        s1_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_hh_reg[i]  <= s0_mag_reg[i][32:16] * s0_mag_reg[i][32:16];
            s1_hl_reg[i]  <= s0_mag_reg[i][32:16] * s0_mag_reg[i][15:0];
            s1_ll_reg[i]  <= s0_mag_reg[i][15:0] * s0_mag_reg[i][15:0];
            s1_mag_reg[i] <= s0_mag_reg[i];
        end
        s1_neg_reg <= s0_neg_reg;
        s1_e0_reg  <= s0_e0_reg;
    end

    // stage 2: squares per axis
    logic [64:0] s2_sq_reg [0:2];
    logic [32:0] s2_mag_reg [0:2];
    logic [2:0]  s2_neg_reg;
    logic [30:0] s2_e0_reg;
    logic        s2_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_sq_reg[i]  <= ({31'd0, s1_hh_reg[i]} << 32) + ({32'd0, s1_hl_reg[i]} << 17)
                           + {33'd0, s1_ll_reg[i]};
            s2_mag_reg[i] <= s1_mag_reg[i];
        end
        s2_neg_reg <= s1_neg_reg;
        s2_e0_reg  <= s1_e0_reg;
    end

    // square root section, entry 0 holds the sum of squares
    hesf_pkg::pipe_t sq_reg  [0:hesf_pkg::SQRT_STEPS];
    hesf_pkg::pipe_t sq_next [0:hesf_pkg::SQRT_STEPS];
    logic [hesf_pkg::SQRT_STEPS:0] sq_vld_reg;

    always_comb
    begin
        sq_next[0]       = '0;
        sq_next[0].neg   = s2_neg_reg;
        sq_next[0].mag_x = s2_mag_reg[0];
        sq_next[0].mag_y = s2_mag_reg[1];
        sq_next[0].mag_z = s2_mag_reg[2];
        sq_next[0].e0    = s2_e0_reg;
        sq_next[0].acc   = {1'b0, s2_sq_reg[0]} + {1'b0, s2_sq_reg[1]} + {1'b0, s2_sq_reg[2]};
    end

    for (genvar j = 1; j <= hesf_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        logic [35:0] r2;
        logic [35:0] trial;

        // one root bit: compare against 4*root+1
        always_comb
        begin
            r2         = {sq_reg[j-1].rem[33:0], sq_reg[j-1].acc[65:64]};
            trial      = {1'b0, sq_reg[j-1].len, 2'b01};
            sq_next[j] = sq_reg[j-1];
            sq_next[j].acc = {sq_reg[j-1].acc[63:0], 2'b00};
            if (r2 >= trial)
            begin
                sq_next[j].rem = r2 - trial;
                sq_next[j].len = {sq_reg[j-1].len[31:0], 1'b1};
            end
            else
            begin
                sq_next[j].rem = r2;
                sq_next[j].len = {sq_reg[j-1].len[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= hesf_pkg::SQRT_STEPS; j++)
            sq_reg[j] <= sq_next[j];
    end

    // stretch stage
    logic [34:0] d_diff;
    logic [34:0] d_abs;
    hesf_pkg::pipe_t d_rec_next;
    hesf_pkg::pipe_t d_rec_reg;
    logic [33:0] d_dmag_reg;
    logic        d_vld_reg;

    always_comb
    begin
        d_diff = {2'b00, sq_reg[hesf_pkg::SQRT_STEPS].len}
               - {4'b0000, sq_reg[hesf_pkg::SQRT_STEPS].e0};
        d_abs  = d_diff[34] ? 35'd0 - d_diff : d_diff;
        d_rec_next      = sq_reg[hesf_pkg::SQRT_STEPS];
        d_rec_next.dneg = d_diff[34];
    end

    always_ff @(posedge clk)
    begin
        d_rec_reg  <= d_rec_next;
        d_dmag_reg <= d_abs[33:0];
    end

    // product stage 1: partials of d*d and 2K*d
    logic [33:0] p1_hh_reg;
    logic [33:0] p1_hl_reg;
    logic [33:0] p1_ll_reg;
    logic [48:0] p1_ch_reg;
    logic [48:0] p1_cl_reg;
    hesf_pkg::pipe_t p1_rec_reg;
    logic        p1_vld_reg;

    always_ff @(posedge clk)
    begin
        p1_hh_reg  <= d_dmag_reg[33:17] * d_dmag_reg[33:17];
        p1_hl_reg  <= d_dmag_reg[33:17] * d_dmag_reg[16:0];
        p1_ll_reg  <= d_dmag_reg[16:0] * d_dmag_reg[16:0];
        p1_ch_reg  <= {stiff_reg, 1'b0} * d_dmag_reg[33:17];
        p1_cl_reg  <= {stiff_reg, 1'b0} * d_dmag_reg[16:0];
        p1_rec_reg <= d_rec_reg;
    end

    // product stage 2: d*d and coefficient numerator
    logic [67:0] p2_dd_reg;
    logic [65:0] p2_cnum_reg;
    hesf_pkg::pipe_t p2_rec_reg;
    logic        p2_vld_reg;

    always_ff @(posedge clk)
    begin
        p2_dd_reg   <= ({34'd0, p1_hh_reg} << 34) + ({34'd0, p1_hl_reg} << 18)
                     + {34'd0, p1_ll_reg};
        p2_cnum_reg <= ({17'd0, p1_ch_reg} << 17) + {17'd0, p1_cl_reg};
        p2_rec_reg  <= p1_rec_reg;
    end

    // product stage 3: partials of K*d*d
    logic [53:0] p3_e0_reg;
    logic [53:0] p3_e1_reg;
    logic [52:0] p3_e2_reg;
    logic [65:0] p3_cnum_reg;
    hesf_pkg::pipe_t p3_rec_reg;
    logic        p3_vld_reg;

    always_ff @(posedge clk)
    begin
        p3_e0_reg   <= p2_dd_reg[22:0] * stiff_reg;
        p3_e1_reg   <= p2_dd_reg[45:23] * stiff_reg;
        p3_e2_reg   <= p2_dd_reg[67:46] * stiff_reg;
        p3_cnum_reg <= p2_cnum_reg;
        p3_rec_reg  <= p2_rec_reg;
    end

    // divide section: coefficient and energy quotients side by side
    hesf_pkg::pipe_t dv_reg  [0:hesf_pkg::CDIV_STEPS];
    hesf_pkg::pipe_t dv_next [0:hesf_pkg::CDIV_STEPS];
    logic [hesf_pkg::CDIV_STEPS:0] dv_vld_reg;
    logic [98:0] dv_kdd;

    always_comb
    begin
        dv_kdd = ({46'd0, p3_e2_reg} << 46) + ({45'd0, p3_e1_reg} << 23)
               + {45'd0, p3_e0_reg};
        dv_next[0]      = p3_rec_reg;
        dv_next[0].acc  = p3_cnum_reg;
        dv_next[0].rem  = '0;
        dv_next[0].eacc = dv_kdd[98:16];
        dv_next[0].erem = '0;
        dv_next[0].eov  = 1'b0;
    end

    for (genvar j = 1; j <= hesf_pkg::CDIV_STEPS; j++)
    begin : g_div
        logic [31:0] cr2;
        logic [31:0] er2;

        always_comb
        begin
            dv_next[j] = dv_reg[j-1];
            // coefficient quotient bit
            cr2 = {dv_reg[j-1].rem[30:0], dv_reg[j-1].acc[65]};
            if (cr2 >= {1'b0, dv_reg[j-1].e0})
            begin
                dv_next[j].rem = {5'd0, cr2[30:0] - dv_reg[j-1].e0};
                dv_next[j].acc = {dv_reg[j-1].acc[64:0], 1'b1};
            end
            else
            begin
                dv_next[j].rem = {5'd0, cr2[30:0]};
                dv_next[j].acc = {dv_reg[j-1].acc[64:0], 1'b0};
            end
            // energy: saturation check first, then 40 quotient bits
            er2 = {dv_reg[j-1].erem, dv_reg[j-1].eacc[82]};
            if (j == 1)
            begin
                dv_next[j].eov  = dv_reg[j-1].eacc[82:40] >= {12'd0, dv_reg[j-1].e0};
                dv_next[j].erem = dv_reg[j-1].eacc[70:40];
                dv_next[j].eacc = {dv_reg[j-1].eacc[39:0], 43'd0};
            end
            else if (j <= hesf_pkg::EDIV_STEPS + 1)
            begin
                if (er2 >= {1'b0, dv_reg[j-1].e0})
                begin
                    dv_next[j].erem = er2[30:0] - dv_reg[j-1].e0;
                    dv_next[j].eacc = {dv_reg[j-1].eacc[81:0], 1'b1};
                end
                else
                begin
                    dv_next[j].erem = er2[30:0];
                    dv_next[j].eacc = {dv_reg[j-1].eacc[81:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= hesf_pkg::CDIV_STEPS; j++)
            dv_reg[j] <= dv_next[j];
    end

    // gradient stage 1: coefficient times |a-b| partials
    hesf_pkg::pipe_t dv_last;
    logic [32:0] g1_mag [0:2];
    logic [54:0] g1_p_reg [0:2][0:2];
    hesf_pkg::grad_t g1_rec_next;
    hesf_pkg::grad_t g1_rec_reg;
    logic        g1_vld_reg;

    always_comb
    begin
        dv_last   = dv_reg[hesf_pkg::CDIV_STEPS];
        g1_mag[0] = dv_last.mag_x;
        g1_mag[1] = dv_last.mag_y;
        g1_mag[2] = dv_last.mag_z;
        g1_rec_next        = '0;
        g1_rec_next.neg    = dv_last.neg;
        g1_rec_next.dneg   = dv_last.dneg;
        g1_rec_next.len    = dv_last.len;
        g1_rec_next.energy = dv_last.eov ? hesf_pkg::ENERGY_MAX : dv_last.eacc[39:0];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            g1_p_reg[i][0] <= dv_last.acc[21:0] * g1_mag[i];
            g1_p_reg[i][1] <= dv_last.acc[43:22] * g1_mag[i];
            g1_p_reg[i][2] <= dv_last.acc[65:44] * g1_mag[i];
        end
        g1_rec_reg <= g1_rec_next;
    end

    // gradient stage 2: full numerators
    logic [98:0] g2_num_reg [0:2];
    hesf_pkg::grad_t g2_rec_reg;
    logic        g2_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            g2_num_reg[i] <= ({44'd0, g1_p_reg[i][2]} << 44) + ({44'd0, g1_p_reg[i][1]} << 22)
                           + {44'd0, g1_p_reg[i][0]};
        g2_rec_reg <= g1_rec_reg;
    end

    // gradient divide section, entry 0 holds the saturation check
    hesf_pkg::grad_t gd_reg  [0:hesf_pkg::GDIV_STEPS];
    hesf_pkg::grad_t gd_next [0:hesf_pkg::GDIV_STEPS];
    logic [hesf_pkg::GDIV_STEPS:0] gd_vld_reg;

    always_comb
    begin
        gd_next[0] = g2_rec_reg;
        for (int i = 0; i < 3; i++)
        begin
            gd_next[0].ov[i]  = g2_num_reg[i][98:32] >= {34'd0, g2_rec_reg.len};
            gd_next[0].rem[i] = g2_num_reg[i][64:32];
            gd_next[0].quo[i] = g2_num_reg[i][31:0];
        end
    end

    for (genvar j = 1; j <= hesf_pkg::GDIV_STEPS; j++)
    begin : g_gdiv
        logic [33:0] r2 [0:2];

        always_comb
        begin
            gd_next[j] = gd_reg[j-1];
            for (int i = 0; i < 3; i++)
            begin
                r2[i] = {gd_reg[j-1].rem[i], gd_reg[j-1].quo[i][31]};
                if (r2[i] >= {1'b0, gd_reg[j-1].len})
                begin
                    gd_next[j].rem[i] = r2[i][32:0] - gd_reg[j-1].len;
                    gd_next[j].quo[i] = {gd_reg[j-1].quo[i][30:0], 1'b1};
                end
                else
                begin
                    gd_next[j].rem[i] = r2[i][32:0];
                    gd_next[j].quo[i] = {gd_reg[j-1].quo[i][30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= hesf_pkg::GDIV_STEPS; j++)
            gd_reg[j] <= gd_next[j];
    end

    // output stage: saturate, sign, negate for b, zero length edge
    hesf_pkg::grad_t o_rec;
    logic        o_sneg [0:2];
    logic [31:0] o_cap  [0:2];
    logic [31:0] o_mag  [0:2];
    logic [31:0] o_ga   [0:2];
    logic [31:0] o_gb   [0:2];
    logic        o_zero;
    logic [31:0] ga_reg [0:2];
    logic [31:0] gb_reg [0:2];
    logic [33:0] len_reg;
    logic [39:0] energy_reg;
    logic        degen_reg;
    logic        done_reg;

    always_comb
    begin
        o_rec  = gd_reg[hesf_pkg::GDIV_STEPS];
        o_zero = (o_rec.len == 33'd0);
        for (int i = 0; i < 3; i++)
        begin
            o_sneg[i] = o_rec.neg[i] != o_rec.dneg;
            o_cap[i]  = o_sneg[i] ? hesf_pkg::NEG_CAP : hesf_pkg::POS_CAP;
            o_mag[i]  = (o_rec.ov[i] || o_rec.quo[i] > o_cap[i]) ? o_cap[i] : o_rec.quo[i];
            o_ga[i]   = o_sneg[i] ? 32'd0 - o_mag[i] : o_mag[i];
            o_gb[i]   = (o_ga[i] == hesf_pkg::NEG_CAP) ? hesf_pkg::POS_CAP : 32'd0 - o_ga[i];
            if (o_zero)
            begin
                o_ga[i] = 32'd0;
                o_gb[i] = 32'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ga_reg[i] <= o_ga[i];
            gb_reg[i] <= o_gb[i];
        end
        len_reg    <= {1'b0, o_rec.len};
        energy_reg <= o_rec.energy;
        degen_reg  <= o_zero;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            sq_vld_reg <= '0;
            d_vld_reg  <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            g1_vld_reg <= 1'b0;
            g2_vld_reg <= 1'b0;
            gd_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= accept;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            sq_vld_reg <= {sq_vld_reg[hesf_pkg::SQRT_STEPS-1:0], s2_vld_reg};
            d_vld_reg  <= sq_vld_reg[hesf_pkg::SQRT_STEPS];
            p1_vld_reg <= d_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            dv_vld_reg <= {dv_vld_reg[hesf_pkg::CDIV_STEPS-1:0], p3_vld_reg};
            g1_vld_reg <= dv_vld_reg[hesf_pkg::CDIV_STEPS];
            g2_vld_reg <= g1_vld_reg;
            gd_vld_reg <= {gd_vld_reg[hesf_pkg::GDIV_STEPS-1:0], g2_vld_reg};
            done_reg   <= gd_vld_reg[hesf_pkg::GDIV_STEPS];
        end
    end

    assign done        = done_reg;
    assign grad_a_x    = ga_reg[0];
    assign grad_a_y    = ga_reg[1];
    assign grad_a_z    = ga_reg[2];
    assign grad_b_x    = gb_reg[0];
    assign grad_b_y    = gb_reg[1];
    assign grad_b_z    = gb_reg[2];
    assign edge_length = len_reg;
    assign energy_term = energy_reg;
    assign degenerate  = degen_reg;

    // every result strobe traces back to an accepted start
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, hesf_pkg::LATENCY))
        else $error("result strobe without matching accepted transaction");

    // zero length edge carries zero gradients
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (grad_a_x == 32'sd0 && grad_a_y == 32'sd0
            && grad_a_z == 32'sd0 && grad_b_x == 32'sd0 && grad_b_y == 32'sd0
            && grad_b_z == 32'sd0))
        else $error("degenerate edge with nonzero gradient");

    // x gradient on b is the negation of x gradient on a, unless a is at the negative cap
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && grad_a_x != hesf_pkg::NEG_CAP) |-> (grad_b_x == 32'd0 - grad_a_x))
        else $error("gradient on b is not the negation of gradient on a");

endmodule
